@@ hw/rtl/banked_ram_scsi_bus_interface_defines.svh @@
// Assertion macros for the banked RAM / SCSI interface checker.
`ifndef BANKED_RAM_SCSI_BUS_INTERFACE_DEFINES_SVH
`define BANKED_RAM_SCSI_BUS_INTERFACE_DEFINES_SVH

// Same-cycle property, sampled on clk, off during reset.
`define BRSBI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BRSBI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/brsbi_pkg.sv @@
// Package: constants, register codes and helpers of the banked RAM / SCSI interface.
package brsbi_pkg;

    localparam int RAM_BYTES = 262144;
    localparam int RAM_AW    = $clog2(RAM_BYTES);
    localparam int BANK_W    = 20;

    localparam logic [15:0] REG_MASK     = 16'hffe3;
    localparam logic [15:0] REG_BANK_LO  = 16'hd1e0;
    localparam logic [15:0] REG_DATA     = 16'hd1e1;
    localparam logic [15:0] REG_CTRL     = 16'hd1e2;
    localparam logic [15:0] REG_ROM      = 16'hd1e3;
    localparam logic [7:0]  WINDOW_PAGE  = 8'hd6;

    localparam logic [7:0] ROM_CODE_S0 = 8'h04;
    localparam logic [7:0] ROM_CODE_S1 = 8'h08;
    localparam logic [7:0] ROM_CODE_S2 = 8'h10;
    localparam logic [7:0] ROM_CODE_S3 = 8'h20;

    localparam logic [2:0] ROM_WIN_SYSTEM = 3'd0;
    localparam logic [2:0] ROM_WIN_MAX    = 3'd4;

    function automatic logic [2:0] rom_window_of(input logic [7:0] code);
        logic [2:0] win;
        case (code)
            ROM_CODE_S0: win = 3'd1;
            ROM_CODE_S1: win = 3'd2;
            ROM_CODE_S2: win = 3'd3;
            ROM_CODE_S3: win = 3'd4;
            default:     win = ROM_WIN_SYSTEM;
        endcase
        return win;
    endfunction

endpackage

@@ hw/rtl/brsbi_if.sv @@
// Interfaces: host access channel and result channel.
interface brsbi_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [15:0] address;
    logic [7:0] write_data;
    logic       peek_only;
    logic [7:0] disk_data_in;
    logic       line_cd;
    logic       line_msg;
    logic       line_io;
    logic       line_bsy;
    logic       line_req;

    modport source (output valid, command, address, write_data, peek_only, disk_data_in,
                    line_cd, line_msg, line_io, line_bsy, line_req, input ready);
    modport sink   (input valid, command, address, write_data, peek_only, disk_data_in,
                    line_cd, line_msg, line_io, line_bsy, line_req, output ready);
endinterface

interface brsbi_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] disk_data_out;
    logic       disk_data_strobe;
    logic       ack_pulse;
    logic       select_line;
    logic [2:0] rom_window;
    logic       ram_window_on;

    modport source (output valid, read_data, disk_data_out, disk_data_strobe, ack_pulse,
                    select_line, rom_window, ram_window_on, input ready);
    modport sink   (input valid, read_data, disk_data_out, disk_data_strobe, ack_pulse,
                    select_line, rom_window, ram_window_on, output ready);
endinterface

@@ hw/rtl/brsbi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module brsbi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/banked_ram_scsi_bus_interface.sv @@
// Top level: banked RAM window and SCSI port on the host bus.
// Takes one host bus access per clock cycle and returns one result item per access;
// each result passes through the registered read port of the banked RAM (stage 1)
// and then the output register, and the sustained rate is one item per cycle as long
// as the sink takes results. Control registers sit in page D1
// (mirrored through mask 0xffe3), page D6 is a 256-byte window onto the RAM at the bank
// offset. After reset the RAM is swept to zero one byte per cycle, and no item is taken
// until the sweep ends; the configuration write port works throughout.
module banked_ram_scsi_bus_interface
    import brsbi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    brsbi_in_if.sink    in_ch,
    brsbi_out_if.source out_ch
);

    // Configuration and architectural state
    logic              scsi_en_reg;
    logic [BANK_W-1:0] bank_reg, bank_next;
    logic              ram_on_reg, ram_on_next;
    logic [7:0]        rom_code_reg, rom_code_next;
    logic              select_reg, select_next;

    // RAM clear sweep
    logic              clearing_reg;
    logic [RAM_AW-1:0] clr_cnt_reg;

    // Stage 1: RAM read in flight
    logic       s1_valid_reg;
    logic       s1_use_ram_reg;
    logic [7:0] s1_rdata_reg;
    logic [7:0] s1_dout_reg;
    logic       s1_strobe_reg;
    logic       s1_ack_reg;
    logic       s1_select_reg;
    logic [2:0] s1_rom_win_reg;
    logic       s1_ram_on_reg;

    // Output register
    logic       out_valid_reg;
    logic [7:0] out_rdata_reg;
    logic [7:0] out_dout_reg;
    logic       out_strobe_reg;
    logic       out_ack_reg;
    logic       out_select_reg;
    logic [2:0] out_rom_win_reg;
    logic       out_ram_on_reg;

    logic              accept;
    logic              advance;
    logic [15:0]       reg_addr;
    logic              hit_bank_lo, hit_data, hit_ctrl, hit_rom, hit_win;
    logic [RAM_AW-1:0] win_addr;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    // Decoded result fields of the accepted access
    logic [7:0] rdata_c;
    logic       use_ram_c;
    logic [7:0] dout_c;
    logic       strobe_c;
    logic       ack_c;

    // Drain stage 1 whenever the output register is empty or being taken
    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !clearing_reg && (!s1_valid_reg || advance);
    assign accept      = in_ch.valid && in_ch.ready;

    assign reg_addr    = in_ch.address & REG_MASK;
    assign hit_bank_lo = (reg_addr == REG_BANK_LO);
    assign hit_data    = (reg_addr == REG_DATA);
    assign hit_ctrl    = (reg_addr == REG_CTRL);
    assign hit_rom     = (reg_addr == REG_ROM);
    assign hit_win     = (in_ch.address[15:8] == WINDOW_PAGE);

    // Window address wraps modulo the RAM size (power of two)
    assign win_addr = RAM_AW'(bank_reg + BANK_W'(in_ch.address[7:0]));

    always_comb
    begin
        bank_next     = bank_reg;
        ram_on_next   = ram_on_reg;
        rom_code_next = rom_code_reg;
        select_next   = select_reg;
        rdata_c       = 8'h00;
        use_ram_c     = 1'b0;
        dout_c        = 8'h00;
        strobe_c      = 1'b0;
        ack_c         = 1'b0;
        if (!in_ch.command)
        begin
            if (hit_ctrl)
            begin
                // Status: inverted target lines
                rdata_c = {~in_ch.line_req, 1'b0, ~in_ch.line_bsy, 2'b00,
                           ~in_ch.line_io, ~in_ch.line_msg, ~in_ch.line_cd};
            end
            else if (hit_data)
            begin
                if (scsi_en_reg)
                begin
                    rdata_c = ~in_ch.disk_data_in;
                    ack_c   = !in_ch.peek_only;
                end
            end
            else if (hit_win)
            begin
                use_ram_c = ram_on_reg;
                rdata_c   = 8'hff;
            end
        end
        else
        begin
            if (hit_bank_lo)
            begin
                bank_next = {bank_reg[BANK_W-1:16], in_ch.write_data, 8'h00};
            end
            else if (hit_data)
            begin
                if (scsi_en_reg)
                begin
                    dout_c   = ~in_ch.write_data;
                    strobe_c = 1'b1;
                    ack_c    = 1'b1;
                end
            end
            else if (hit_ctrl)
            begin
                bank_next   = {in_ch.write_data[3:0], bank_reg[15:0]};
                ram_on_next = in_ch.write_data[5];
                if (scsi_en_reg)
                begin
                    select_next = in_ch.write_data[4];
                end
            end
            else if (hit_rom)
            begin
                rom_code_next = in_ch.write_data;
            end
        end
    end

    // RAM port use: the sweep owns the write port until it finishes
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = 8'h00;
        end
        else
        begin
            ram_we    = accept && in_ch.command && hit_win && !hit_bank_lo && !hit_data
                        && !hit_ctrl && !hit_rom && ram_on_reg;
            ram_waddr = win_addr;
            ram_wdata = in_ch.write_data;
        end
    end

    // Read on accept only, so the read data holds while stage 1 stalls
    brsbi_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (win_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scsi_en_reg  <= 1'b0;
            bank_reg     <= '0;
            ram_on_reg   <= 1'b0;
            rom_code_reg <= 8'h00;
            select_reg   <= 1'b0;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                scsi_en_reg <= cfg_wdata;
            end
            if (accept)
            begin
                bank_reg     <= bank_next;
                ram_on_reg   <= ram_on_next;
                rom_code_reg <= rom_code_next;
                select_reg   <= select_next;
            end
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + RAM_AW'(1);
                if (clr_cnt_reg == RAM_AW'(RAM_BYTES - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    // Stage 1 and output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold results with the state as it stands after the access
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_use_ram_reg <= use_ram_c;
            s1_rdata_reg   <= rdata_c;
            s1_dout_reg    <= dout_c;
            s1_strobe_reg  <= strobe_c;
            s1_ack_reg     <= ack_c;
            s1_select_reg  <= select_next;
            s1_rom_win_reg <= rom_window_of(rom_code_next);
            s1_ram_on_reg  <= ram_on_next;
        end
        if (advance)
        begin
            out_rdata_reg   <= s1_use_ram_reg ? ram_rdata : s1_rdata_reg;
            out_dout_reg    <= s1_dout_reg;
            out_strobe_reg  <= s1_strobe_reg;
            out_ack_reg     <= s1_ack_reg;
            out_select_reg  <= s1_select_reg;
            out_rom_win_reg <= s1_rom_win_reg;
            out_ram_on_reg  <= s1_ram_on_reg;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.read_data        = out_rdata_reg;
    assign out_ch.disk_data_out    = out_dout_reg;
    assign out_ch.disk_data_strobe = out_strobe_reg;
    assign out_ch.ack_pulse        = out_ack_reg;
    assign out_ch.select_line      = out_select_reg;
    assign out_ch.rom_window       = out_rom_win_reg;
    assign out_ch.ram_window_on    = out_ram_on_reg;

endmodule

@@ hw/rtl/brsbi_checker.sv @@
// Port-level checker for the banked RAM / SCSI interface, bound to the top level.
`include "banked_ram_scsi_bus_interface_defines.svh"

module brsbi_checker
    import brsbi_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] read_data,
    input logic [7:0] disk_data_out,
    input logic       disk_data_strobe,
    input logic       ack_pulse,
    input logic [2:0] rom_window
);

    `BRSBI_ASSERT(a_strobe_acks, !(out_valid && disk_data_strobe) || ack_pulse, "strobe without ack")

    `BRSBI_ASSERT(a_dout_quiet, !(out_valid && !disk_data_strobe) || (disk_data_out == 8'h00), "data out without strobe")

    `BRSBI_ASSERT(a_rom_range, !out_valid || (rom_window <= ROM_WIN_MAX), "rom window code out of range")

    `BRSBI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(ack_pulse), "stalled result changed")

endmodule

bind banked_ram_scsi_bus_interface brsbi_checker u_brsbi_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .read_data        (out_ch.read_data),
    .disk_data_out    (out_ch.disk_data_out),
    .disk_data_strobe (out_ch.disk_data_strobe),
    .ack_pulse        (out_ch.ack_pulse),
    .rom_window       (out_ch.rom_window)
);
